/* sv/lw_pkg.sv */
// Shared types, constants and the character width table of the line wrapper.
// No dependencies; every other file refers to this package by scoped names.
package lw_pkg;

    localparam int WINDOW_BYTES = 1024;
    localparam int LINE_SLOTS   = 44;
    localparam int LINE_CHARS   = LINE_SLOTS - 1;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int WIN_CW       = $clog2(WINDOW_BYTES + 1);
    localparam int LB_AW        = $clog2(LINE_CHARS);
    localparam int K_W          = $clog2(LINE_SLOTS);
    localparam int LIMIT_W      = 13;
    localparam int SUM_W        = 14;
    localparam int BC_W         = 11;
    localparam int PX_W         = 11;
    localparam int CW_W         = 7;
    localparam int QUEUE_DEPTH  = 4;
    localparam int Q_AW         = $clog2(QUEUE_DEPTH);
    localparam int Q_CW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1312;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'h80;

    localparam logic [CW_W-1:0] W_SPACE  = 7'd36;
    localparam logic [CW_W-1:0] W_NARROW = 7'd26;
    localparam logic [CW_W-1:0] W_SLIM   = 7'd38;
    localparam logic [CW_W-1:0] W_WIDE   = 7'd88;
    localparam logic [CW_W-1:0] W_UPPER  = 7'd72;
    localparam logic [CW_W-1:0] W_DIGIT  = 7'd60;
    localparam logic [CW_W-1:0] W_BASE   = 7'd58;
    localparam logic [CW_W-1:0] W_NONE   = 7'd0;

    typedef enum logic [1:0] {
        WHY_PARAGRAPH = 2'd0,
        WHY_TOO_WIDE  = 2'd1,
        WHY_FULL      = 2'd2,
        WHY_END       = 2'd3
    } why_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_CR    = 2'd1,
        KIND_LF    = 2'd2,
        KIND_BLANK = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]      data;
        kind_t           kind;
        logic [CW_W-1:0] width;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   last;
    } item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_CHAR,
        ST_LOOK,
        ST_LOOKD,
        ST_FINISH,
        ST_ERD,
        ST_EOUT,
        ST_SOUT
    } state_t;

    function automatic logic [CW_W-1:0] class_width(input logic [7:0] c);
        logic [CW_W-1:0] w;
        if (c == CH_SPACE) begin
            w = W_SPACE;
        end else if (c < CH_SPACE) begin
            w = W_NONE;
        end else if (c >= CH_HIGH) begin
            w = W_WIDE;
        end else begin
            unique case (c)
                8'h69, 8'h6A, 8'h6C, 8'h2E, 8'h2C, 8'h3A, 8'h3B,
                8'h27, 8'h21, 8'h7C, 8'h60: w = W_NARROW;
                8'h66, 8'h72, 8'h74, 8'h28, 8'h29,
                8'h5B, 8'h5D, 8'h2D:        w = W_SLIM;
                8'h6D, 8'h77, 8'h4D, 8'h57, 8'h40: w = W_WIDE;
                default: begin
                    if (c >= 8'h41 && c <= 8'h5A) w = W_UPPER;
                    else if (c >= 8'h30 && c <= 8'h39) w = W_DIGIT;
                    else w = W_BASE;
                end
            endcase
        end
        return w;
    endfunction

endpackage

/* sv/lw_front.sv */
// Input side of the line wrapper: takes text bytes and tags each with its
// kind and class width. Depends on lw_pkg.
module lw_front (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // text_byte
    input  logic           s_tlast,   // window_end
    output logic           push_valid,
    input  logic           push_ready,
    output lw_pkg::item_t  push_item
);

    lw_pkg::kind_t kind;

    always_comb begin
        priority if (s_tdata == lw_pkg::CH_CR) begin
            kind = lw_pkg::KIND_CR;
        end else if (s_tdata == lw_pkg::CH_LF) begin
            kind = lw_pkg::KIND_LF;
        end else if (s_tdata == lw_pkg::CH_SPACE || s_tdata == lw_pkg::CH_TAB) begin
            kind = lw_pkg::KIND_BLANK;
        end else begin
            kind = lw_pkg::KIND_OTHER;
        end
    end

    assign push_valid            = s_tvalid;
    assign s_tready              = push_ready;
    assign push_item.entry.data  = s_tdata;
    assign push_item.entry.kind  = kind;
    assign push_item.entry.width = lw_pkg::class_width(s_tdata);
    assign push_item.last        = s_tlast;

endmodule

/* sv/lw_queue.sv */
// Short item queue between the classifying front and the wrap engine.
// Depends on lw_pkg for the item type and depth.
module lw_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lw_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output lw_pkg::item_t out_item
);

    lw_pkg::item_t               slot_reg [lw_pkg::QUEUE_DEPTH];
    logic [lw_pkg::Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lw_pkg::Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lw_pkg::Q_CW-1:0]     count_reg, count_next;
    logic                        push, pop;

    assign in_ready  = count_reg != lw_pkg::Q_CW'(lw_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? lw_pkg::Q_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? lw_pkg::Q_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = lw_pkg::Q_CW'(count_reg + 1'b1);
        if (pop && !push) count_next = lw_pkg::Q_CW'(count_reg - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

/* sv/lw_back.sv */
// Wrap engine: window store, greedy line scan, line buffer and result output.
// Depends on lw_pkg.
module lw_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lw_pkg::LIMIT_W-1:0]  limit,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  lw_pkg::item_t               q_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    lw_pkg::entry_t win_mem [lw_pkg::WINDOW_BYTES];
    logic [7:0]     lb_mem  [lw_pkg::LINE_CHARS];

    lw_pkg::state_t state_reg, state_next;
    logic [lw_pkg::WIN_CW-1:0] count_reg, count_next;
    logic [lw_pkg::WIN_CW-1:0] i_reg, i_next;
    logic [lw_pkg::WIN_CW-1:0] j_reg, j_next;
    logic [lw_pkg::WIN_CW-1:0] sp_src_reg, sp_src_next;
    logic [lw_pkg::WIN_CW-1:0] used_reg, used_next;
    logic [lw_pkg::K_W-1:0]    k_reg, k_next;
    logic [lw_pkg::K_W-1:0]    sp_out_reg, sp_out_next;
    logic [lw_pkg::K_W-1:0]    len_reg, len_next;
    logic [lw_pkg::K_W-1:0]    e_reg, e_next;
    logic [lw_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic have_sp_reg, have_sp_next;
    logic last_sp_reg, last_sp_next;
    logic broke_reg, broke_next;
    logic para_reg, para_next;
    lw_pkg::why_t why_reg, why_next;

    lw_pkg::entry_t rd_data_reg;
    logic [7:0]     lb_rd_reg;

    logic                      win_we, win_re, lb_we, lb_re;
    logic [lw_pkg::WIN_AW-1:0] rd_addr;
    logic                      add_fire, no_space_slot, gap;
    logic [7:0]                add_char;
    logic [lw_pkg::CW_W-1:0]   add_w;
    logic [lw_pkg::WIN_CW-1:0] add_src;
    logic [lw_pkg::SUM_W-1:0]  sum_add;

    assign no_space_slot = (k_reg == '0) || last_sp_reg;
    assign gap = rd_data_reg.kind == lw_pkg::KIND_CR || rd_data_reg.kind == lw_pkg::KIND_BLANK;

    // character to append this cycle, if any
    always_comb begin
        add_fire = 1'b0;
        add_char = lw_pkg::CH_SPACE;
        add_w    = lw_pkg::W_SPACE;
        add_src  = i_reg;
        unique case (state_reg)
            lw_pkg::ST_CHAR: begin
                if (rd_data_reg.kind == lw_pkg::KIND_OTHER) begin
                    add_fire = 1'b1;
                    add_char = rd_data_reg.data;
                    add_w    = rd_data_reg.width;
                end else if (rd_data_reg.kind == lw_pkg::KIND_BLANK && !no_space_slot) begin
                    add_fire = 1'b1;
                end
            end
            lw_pkg::ST_LOOKD: begin
                if (!gap && rd_data_reg.kind != lw_pkg::KIND_LF && !para_reg
                        && !no_space_slot) begin
                    add_fire = 1'b1;
                    add_src  = lw_pkg::WIN_CW'(j_reg - 1'b1);
                end
            end
            default: ;
        endcase
    end

    assign sum_add = lw_pkg::SUM_W'(sum_reg + lw_pkg::SUM_W'(add_w));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        sp_src_next  = sp_src_reg;
        used_next    = used_reg;
        k_next       = k_reg;
        sp_out_next  = sp_out_reg;
        len_next     = len_reg;
        e_next       = e_reg;
        sum_next     = sum_reg;
        have_sp_next = have_sp_reg;
        last_sp_next = last_sp_reg;
        broke_next   = broke_reg;
        para_next    = para_reg;
        why_next     = why_reg;
        win_we       = 1'b0;
        win_re       = 1'b0;
        lb_we        = 1'b0;
        lb_re        = 1'b0;
        rd_addr      = i_reg[lw_pkg::WIN_AW-1:0];
        q_ready      = 1'b0;
        m_tvalid     = 1'b0;

        unique case (state_reg)
            lw_pkg::ST_LOAD: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (count_reg < lw_pkg::WIN_CW'(lw_pkg::WINDOW_BYTES)) begin
                        win_we     = 1'b1;
                        count_next = lw_pkg::WIN_CW'(count_reg + 1'b1);
                    end
                    if (q_item.last) begin
                        i_next       = '0;
                        k_next       = '0;
                        sum_next     = '0;
                        have_sp_next = 1'b0;
                        last_sp_next = 1'b0;
                        broke_next   = 1'b0;
                        sp_src_next  = '0;
                        sp_out_next  = '0;
                        state_next   = lw_pkg::ST_SCAN;
                    end
                end
            end
            lw_pkg::ST_SCAN: begin
                if (i_reg < count_reg && k_reg < lw_pkg::K_W'(lw_pkg::LINE_CHARS)) begin
                    win_re     = 1'b1;
                    state_next = lw_pkg::ST_CHAR;
                end else begin
                    state_next = lw_pkg::ST_FINISH;
                end
            end
            lw_pkg::ST_CHAR: begin
                unique case (rd_data_reg.kind)
                    lw_pkg::KIND_LF: begin
                        j_next     = lw_pkg::WIN_CW'(i_reg + 1'b1);
                        para_next  = 1'b0;
                        state_next = lw_pkg::ST_LOOK;
                    end
                    lw_pkg::KIND_CR, lw_pkg::KIND_BLANK: begin
                        i_next     = lw_pkg::WIN_CW'(i_reg + 1'b1);
                        state_next = lw_pkg::ST_SCAN;
                    end
                    default: ;
                endcase
            end
            lw_pkg::ST_LOOK: begin
                rd_addr = j_reg[lw_pkg::WIN_AW-1:0];
                if (j_reg < count_reg) begin
                    win_re     = 1'b1;
                    state_next = lw_pkg::ST_LOOKD;
                end else begin
                    len_next   = k_reg;
                    e_next     = '0;
                    state_next = lw_pkg::ST_ERD;
                    if (para_reg) begin
                        used_next = j_reg;
                        why_next  = lw_pkg::WHY_PARAGRAPH;
                    end else begin
                        used_next = lw_pkg::WIN_CW'(i_reg + 1'b1);
                        why_next  = lw_pkg::WHY_END;
                    end
                end
            end
            lw_pkg::ST_LOOKD: begin
                if (gap || rd_data_reg.kind == lw_pkg::KIND_LF) begin
                    if (rd_data_reg.kind == lw_pkg::KIND_LF) para_next = 1'b1;
                    j_next     = lw_pkg::WIN_CW'(j_reg + 1'b1);
                    state_next = lw_pkg::ST_LOOK;
                end else if (para_reg) begin
                    used_next  = j_reg;
                    why_next   = lw_pkg::WHY_PARAGRAPH;
                    len_next   = k_reg;
                    e_next     = '0;
                    state_next = lw_pkg::ST_ERD;
                end else begin
                    i_next     = j_reg;
                    state_next = lw_pkg::ST_SCAN;
                end
            end
            lw_pkg::ST_FINISH: begin
                e_next     = '0;
                state_next = lw_pkg::ST_ERD;
                priority if (broke_reg) why_next = lw_pkg::WHY_TOO_WIDE;
                else if (i_reg >= count_reg) why_next = lw_pkg::WHY_END;
                else why_next = lw_pkg::WHY_FULL;
                priority if (!broke_reg && i_reg >= count_reg) begin
                    len_next  = k_reg;
                    used_next = i_reg;
                end else if (have_sp_reg && sp_out_reg != '0) begin
                    len_next  = sp_out_reg;
                    used_next = lw_pkg::WIN_CW'(sp_src_reg + 1'b1);
                end else begin
                    len_next  = k_reg;
                    used_next = (i_reg != '0) ? i_reg : lw_pkg::WIN_CW'(1);
                end
            end
            lw_pkg::ST_ERD: begin
                if (e_reg < len_reg) begin
                    lb_re      = 1'b1;
                    state_next = lw_pkg::ST_EOUT;
                end else begin
                    state_next = lw_pkg::ST_SOUT;
                end
            end
            lw_pkg::ST_EOUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    e_next     = lw_pkg::K_W'(e_reg + 1'b1);
                    state_next = lw_pkg::ST_ERD;
                end
            end
            lw_pkg::ST_SOUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    count_next = '0;
                    state_next = lw_pkg::ST_LOAD;
                end
            end
            default: state_next = lw_pkg::ST_LOAD;
        endcase

        if (add_fire) begin
            sum_next = sum_add;
            if (sum_add > lw_pkg::SUM_W'(limit)) begin
                // the overflowing character is not consumed
                broke_next = 1'b1;
                i_next     = add_src;
                state_next = lw_pkg::ST_FINISH;
            end else begin
                if (add_char == lw_pkg::CH_SPACE) begin
                    have_sp_next = 1'b1;
                    sp_src_next  = add_src;
                    sp_out_next  = k_reg;
                end
                lb_we        = 1'b1;
                k_next       = lw_pkg::K_W'(k_reg + 1'b1);
                last_sp_next = add_char == lw_pkg::CH_SPACE;
                i_next       = lw_pkg::WIN_CW'(add_src + 1'b1);
                state_next   = lw_pkg::ST_SCAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lw_pkg::ST_LOAD;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        sp_src_reg  <= sp_src_next;
        used_reg    <= used_next;
        k_reg       <= k_next;
        sp_out_reg  <= sp_out_next;
        len_reg     <= len_next;
        e_reg       <= e_next;
        sum_reg     <= sum_next;
        have_sp_reg <= have_sp_next;
        last_sp_reg <= last_sp_next;
        broke_reg   <= broke_next;
        para_reg    <= para_next;
        why_reg     <= why_next;
    end

    always_ff @(posedge aclk) begin
        if (win_we) win_mem[count_reg[lw_pkg::WIN_AW-1:0]] <= q_item.entry;
        if (win_re) rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (lb_we) lb_mem[k_reg[lw_pkg::LB_AW-1:0]] <= add_char;
        if (lb_re) lb_rd_reg <= lb_mem[e_reg[lw_pkg::LB_AW-1:0]];
    end

    always_comb begin
        if (state_reg == lw_pkg::ST_SOUT) begin
            m_tuser = 1'b0;
            m_tlast = 1'b1;
            m_tdata = {why_reg, sum_reg[lw_pkg::SUM_W-1:3],
                       lw_pkg::BC_W'(used_reg), 8'd0};
        end else begin
            m_tuser = 1'b1;
            m_tlast = 1'b0;
            m_tdata = {24'd0, lb_rd_reg};
        end
    end

endmodule

/* sv/proportional_text_line_wrapper.sv */
// Top level of the greedy proportional-width line wrapper: config register,
// front classifier, item queue and wrap engine. Depends on lw_pkg and submodules.
//
// Text bytes stream in one per cycle, while the queue has room, into a 1024-byte
// window store; the byte flagged with s_tlast starts a wrap. The wrap engine scans
// the store with one registered memory read and one decision per byte, and reads
// newline lookahead bytes the same way, then emits each line character, stalling
// on m_tready, followed by one summary item. Input stays accepted into a 4-item
// queue while a wrap runs and stalls once it fills. The width limit is written
// through cfg_valid/cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. The window store needs no clearing after reset.
module proportional_text_line_wrapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // window_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] line_char, [18:8] bytes_consumed,
                                   // [29:19] width_px, [31:30] break_reason
    output logic        m_tlast,   // is_last
    output logic        m_tuser,   // [0] has_char
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // width_limit_eighths
);

    logic [lw_pkg::LIMIT_W-1:0] limit_reg;
    logic                       push_valid, push_ready, q_valid, q_ready;
    lw_pkg::item_t              push_item, q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= lw_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    lw_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .limit    (limit_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_summary_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser && m_tdata[7:0] == 8'd0)
        else $error("summary item carries a character");

    a_char_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && m_tdata[31:8] == 24'd0)
        else $error("character item carries summary fields");

    a_summary_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[18:8] != 11'd0)
        else $error("line consumed no bytes");

endmodule

/* dv/tb.sv */
// Self-checking bench for proportional_text_line_wrapper: streams text windows, predicts
// each wrapped line and its summary item, and compares every result item field by field.
// Depends on lw_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned STALL_LIMIT   = 20000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 40;

    typedef logic [7:0] text_q_t [$];

    typedef struct packed {
        logic         has_char;
        logic [7:0]   ch;
        logic         is_last;
        logic [10:0]  consumed;
        logic [10:0]  px;
        lw_pkg::why_t why;
    } line_item_t;

    typedef struct packed {
        logic [7:0]   text;
        logic         last;
        logic         typed;
        logic         shows_char;
        logic [10:0]  consumed;
        logic [10:0]  px;
        lw_pkg::why_t why;
    } probe_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = 13'd0;

    // predictor state
    logic [7:0]   win_bytes [lw_pkg::WINDOW_BYTES];
    int unsigned  win_fill = 0;
    logic [12:0]  limit_eighths = lw_pkg::LIMIT_RESET;
    logic [7:0]   line_text [lw_pkg::LINE_CHARS];
    line_item_t   owed_items [$];

    int unsigned mismatch_count = 0;
    int unsigned windows_sent   = 0;
    int unsigned text_items     = 0;
    int unsigned result_items   = 0;
    int unsigned idle_cycles    = 0;
    int unsigned burst_left     = 0;
    bit          sender_calm    = 1'b0;

    logic        sink_calm  = 1'b0;
    int unsigned hold_asked = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned sink_run   = 0;

    probe_row_t probe_rows [24] = '{
        '{8'h41,            1'b1, 1'b1, 1'b1, 11'd1, 11'd9,  lw_pkg::WHY_END},
        '{lw_pkg::CH_CR,    1'b1, 1'b1, 1'b0, 11'd1, 11'd0,  lw_pkg::WHY_END},
        '{lw_pkg::CH_LF,    1'b1, 1'b1, 1'b0, 11'd1, 11'd0,  lw_pkg::WHY_END},
        '{8'hFF,            1'b1, 1'b1, 1'b1, 11'd1, 11'd11, lw_pkg::WHY_END},
        '{8'h00,            1'b1, 1'b1, 1'b1, 11'd1, 11'd0,  lw_pkg::WHY_END},
        '{lw_pkg::CH_TAB,   1'b1, 1'b1, 1'b0, 11'd1, 11'd0,  lw_pkg::WHY_END},
        '{8'h61,            1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{8'h62,            1'b1, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{8'h78,            1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_CR,    1'b1, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_TAB,   1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{8'h57,            1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{8'h2C,            1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{8'h69,            1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_CR,    1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{lw_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH},
        '{8'h66,            1'b1, 1'b0, 1'b0, 11'd0, 11'd0,  lw_pkg::WHY_PARAGRAPH}
    };

    proportional_text_line_wrapper DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned glyph_eighths(input logic [7:0] c);
        if (c == lw_pkg::CH_SPACE) return 32'(lw_pkg::W_SPACE);
        if (c < lw_pkg::CH_SPACE) return 32'(lw_pkg::W_NONE);
        if (c >= lw_pkg::CH_HIGH) return 32'(lw_pkg::W_WIDE);
        case (c)
            8'h69, 8'h6A, 8'h6C, 8'h2E, 8'h2C, 8'h3A, 8'h3B,
            8'h27, 8'h21, 8'h7C, 8'h60:               return 32'(lw_pkg::W_NARROW);
            8'h66, 8'h72, 8'h74, 8'h28, 8'h29,
            8'h5B, 8'h5D, 8'h2D:                      return 32'(lw_pkg::W_SLIM);
            8'h6D, 8'h77, 8'h4D, 8'h57, 8'h40:        return 32'(lw_pkg::W_WIDE);
            default: ;
        endcase
        if (c >= 8'h41 && c <= 8'h5A) return 32'(lw_pkg::W_UPPER);
        if (c >= 8'h30 && c <= 8'h39) return 32'(lw_pkg::W_DIGIT);
        return 32'(lw_pkg::W_BASE);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == lw_pkg::CH_CR || c == lw_pkg::CH_SPACE || c == lw_pkg::CH_TAB;
    endfunction

    // greedy wrap of the stored window; queues the line items and the summary
    function automatic void wrap_window(input bit muted);
        int unsigned  i, j, k, sum, sp_src, sp_out, used, len;
        bit           have_space, width_broke, settled;
        logic [7:0]   c;
        lw_pkg::why_t why;
        i = 0; k = 0; sum = 0; sp_src = 0; sp_out = 0; used = 0; len = 0;
        have_space = 1'b0; width_broke = 1'b0; settled = 1'b0;
        why = lw_pkg::WHY_END;
        while (i < win_fill && k < lw_pkg::LINE_CHARS) begin
            c = win_bytes[i];
            if (c == lw_pkg::CH_CR) begin
                i++;
                continue;
            end
            if (c == lw_pkg::CH_LF) begin
                j = i + 1;
                while (j < win_fill && is_blank(win_bytes[j])) j++;
                if (j < win_fill && win_bytes[j] == lw_pkg::CH_LF) begin
                    while (j < win_fill && (is_blank(win_bytes[j])
                                            || win_bytes[j] == lw_pkg::CH_LF))
                        j++;
                    len = k; used = j; why = lw_pkg::WHY_PARAGRAPH; settled = 1'b1;
                    break;
                end
                if (j >= win_fill) begin
                    len = k; used = i + 1; why = lw_pkg::WHY_END; settled = 1'b1;
                    break;
                end
                c = lw_pkg::CH_SPACE;
                i = j - 1;
            end
            if (c == lw_pkg::CH_SPACE || c == lw_pkg::CH_TAB) begin
                if (k == 0 || line_text[k-1] == lw_pkg::CH_SPACE) begin
                    i++;
                    continue;
                end
                c = lw_pkg::CH_SPACE;
            end
            sum += glyph_eighths(c);
            if (sum > limit_eighths) begin
                width_broke = 1'b1;
                break;
            end
            if (c == lw_pkg::CH_SPACE) begin
                have_space = 1'b1; sp_src = i; sp_out = k;
            end
            line_text[k] = c;
            k++;
            i++;
        end
        if (!settled) begin
            if (width_broke) why = lw_pkg::WHY_TOO_WIDE;
            else if (i >= win_fill) why = lw_pkg::WHY_END;
            else why = lw_pkg::WHY_FULL;
            if (!width_broke && i >= win_fill) begin
                len = k; used = i;
            end else if (have_space && sp_out > 0) begin
                len = sp_out; used = sp_src + 1;
            end else begin
                len = k; used = (i > 0) ? i : 1;
            end
        end
        if (muted) return;
        for (int n = 0; n < int'(len); n++)
            owed_items.insert(owed_items.size(),
                              '{1'b1, line_text[n], 1'b0, 11'd0, 11'd0,
                                lw_pkg::WHY_PARAGRAPH});
        owed_items.insert(owed_items.size(),
                          '{1'b0, 8'h00, 1'b1, 11'(used), 11'(sum / 8), why});
    endfunction

    function automatic void take_text(input logic [7:0] b, input bit last, input bit muted);
        if (win_fill < lw_pkg::WINDOW_BYTES) begin
            win_bytes[win_fill] = b;
            win_fill++;
        end
        if (last) begin
            wrap_window(muted);
            win_fill = 0;
        end
    endfunction

    function automatic logic [7:0] pick_glyph();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7A));
            4:          return 8'($urandom_range(8'h41, 8'h5A));
            5:          return 8'($urandom_range(8'h30, 8'h39));
            6:          return 8'($urandom_range(8'h21, 8'h2F));
            7:          return 8'($urandom_range(8'h80, 8'hFF));
            8:          return 8'($urandom_range(8'h00, 8'h1F));
            default:    return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // words with spaces, tabs and line ends; a tenth of the windows are raw noise
    function automatic text_q_t compose_window(input int unsigned target, input bit with_breaks);
        text_q_t     t;
        int unsigned pick;
        if ($urandom_range(0, 9) == 0) begin
            repeat (target) t.insert(t.size(), 8'($urandom));
            return t;
        end
        while (t.size() < target) begin
            pick = $urandom_range(0, with_breaks ? 19 : 16);
            if (pick < 12) t.insert(t.size(), pick_glyph());
            else if (pick < 15) t.insert(t.size(), lw_pkg::CH_SPACE);
            else if (pick == 15) t.insert(t.size(), lw_pkg::CH_TAB);
            else if (pick == 16) t.insert(t.size(), lw_pkg::CH_CR);
            else if (pick == 17) t.insert(t.size(), lw_pkg::CH_LF);
            else if (pick == 18) begin
                t.insert(t.size(), lw_pkg::CH_LF);
                t.insert(t.size(), lw_pkg::CH_SPACE);
                t.insert(t.size(), lw_pkg::CH_LF);
            end else begin
                t.insert(t.size(), lw_pkg::CH_CR);
                t.insert(t.size(), lw_pkg::CH_LF);
            end
        end
        return t;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic send_text(input logic [7:0] b, input bit last, input bit muted);
        int unsigned gap;
        if (burst_left == 0) begin
            if (sender_calm) gap = 0;
            else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 30);
            else gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        text_items++;
        take_text(b, last, muted);
    endtask

    task automatic send_window(input text_q_t text);
        foreach (text[n]) send_text(text[n], n == text.size() - 1, 1'b0);
        windows_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (owed_items.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [12:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_eighths = value;
    endtask

    task automatic run_random_phase(input int unsigned budget, input bit steady);
        text_q_t     text;
        int unsigned sent;
        int unsigned target;
        sent = 0;
        while (sent < budget) begin
            sender_calm = steady || ($urandom_range(0, 4) == 0);
            target = ($urandom_range(0, 5) == 0) ? $urandom_range(45, 80)
                                                 : $urandom_range(1, 24);
            text = compose_window(target, $urandom_range(0, 2) != 0);
            send_window(text);
            sent += text.size();
            if ($urandom_range(0, 7) == 0) drain_results();
        end
    endtask

    // receiver pacing: alternating ready and stall runs, a one-off long hold, or always ready
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (sink_calm) begin
            m_tready <= 1'b1;
        end else if (sink_run != 0) begin
            sink_run <= sink_run - 1;
        end else begin
            m_tready <= ~m_tready;
            sink_run <= m_tready ? $urandom_range(0, 5) : $urandom_range(0, 12);
        end
    end

    always @(posedge aclk) begin : line_check
        line_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_items++;
            if (owed_items.size() == 0) begin
                flag_mismatch("item with nothing awaited, tdata", int'(m_tdata), 0);
            end else begin
                want = owed_items.pop_front();
                if (m_tuser != want.has_char)
                    flag_mismatch("has_char", int'(m_tuser), int'(want.has_char));
                if (m_tdata[7:0] != want.ch)
                    flag_mismatch("line_char", int'(m_tdata[7:0]), int'(want.ch));
                if (m_tlast != want.is_last)
                    flag_mismatch("is_last", int'(m_tlast), int'(want.is_last));
                if (m_tdata[18:8] != want.consumed)
                    flag_mismatch("bytes_consumed", int'(m_tdata[18:8]), int'(want.consumed));
                if (m_tdata[29:19] != want.px)
                    flag_mismatch("width_px", int'(m_tdata[29:19]), int'(want.px));
                if (m_tdata[31:30] != want.why)
                    flag_mismatch("break_reason", int'(m_tdata[31:30]), int'(want.why));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probe_rows[r]) begin
            send_text(probe_rows[r].text, probe_rows[r].last, probe_rows[r].typed);
            if (probe_rows[r].typed) begin
                if (probe_rows[r].shows_char)
                    owed_items.insert(owed_items.size(),
                                      '{1'b1, probe_rows[r].text, 1'b0, 11'd0, 11'd0,
                                        lw_pkg::WHY_PARAGRAPH});
                owed_items.insert(owed_items.size(),
                                  '{1'b0, 8'h00, 1'b1, probe_rows[r].consumed,
                                    probe_rows[r].px, probe_rows[r].why});
            end
            if (probe_rows[r].last) windows_sent++;
        end

        // widest limit, with a long output hold while input keeps coming
        set_limit(13'h1FFF);
        hold_asked <= hold_asked + 1;
        run_random_phase(40, 1'b0);

        set_limit(13'd0);
        run_random_phase(10, 1'b0);

        set_limit(13'd180);
        sink_calm <= 1'b1;
        run_random_phase(25, 1'b1);
        drain_results();
        sink_calm <= 1'b0;

        set_limit(13'($urandom_range(150, 1000)));
        run_random_phase(25, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d windows, %0d text items, %0d result items, limits 0 to 8191.",
                 windows_sent, text_items, result_items);
        $display("Included paragraph, width and full-line breaks and a long output hold.");
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
